@@ design/mvea_pkg.sv @@
// ----------------------------------------------------------------------------
// mvea_pkg
// Request codes and configuration register indexes of the vector element ALU.
// ----------------------------------------------------------------------------
package mvea_pkg;

	localparam int OP_W = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
	localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
	localparam logic [OP_W-1:0] OP_CRED   = 3'd3;
	localparam logic [OP_W-1:0] OP_SWITCH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 1'd1;

endpackage

@@ design/mvea_if.sv @@
// ----------------------------------------------------------------------------
// mvea request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface mvea_req_if #(parameter int VALUE_BITS = 64);
	logic                  valid;
	logic                  ready;
	logic [2:0]            req_type;
	logic [VALUE_BITS-1:0] operand_a;
	logic [VALUE_BITS-1:0] operand_b;

	modport source (output valid, req_type, operand_a, operand_b, input ready);
	modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface mvea_rsp_if #(parameter int VALUE_BITS = 64);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] result_value;

	modport source (output valid, result_value, input ready);
	modport sink   (input valid, result_value, output ready);
endinterface

@@ design/modular_vector_element_alu.sv @@
// ----------------------------------------------------------------------------
// modular_vector_element_alu
// Modular add/sub/mul mod q, centered reduction and modulus switch to p.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  req       in   valid/ready      req_type, operand_a, operand_b
//  rsp       out  valid/ready      result_value
//  cfg       in   cfg_we           cfg_idx, cfg_wdata (modulus, target_modulus)
//
//  One item enters per cycle unless the output stalls. The pipeline holds
//  an entry stage, bit-serial remainder stages (one dividend bit each), a
//  zero-modulus fix stage, bit-serial multiply stages and an output stage.
//  arst_n clears all pipeline registers and sets both moduli to two.
//  A stalled output freezes the whole pipeline; req.ready follows it.
//
module modular_vector_element_alu #(
	parameter int VALUE_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mvea_req_if.sink                            req,
	mvea_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [mvea_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [VALUE_BITS-1:0]               cfg_wdata
);
	import mvea_pkg::*;

	localparam int W   = VALUE_BITS;
	localparam int NST = 2 * W + 2;

	typedef struct packed {
		logic          vld;
		logic [OP_W-1:0] op;
		logic [W-1:0]  x;
		logic [W-1:0]  y;
		logic [W-1:0]  q;
		logic [W-1:0]  p;
		logic [W-1:0]  diff;
		logic          qlp;
		logic [W-1:0]  rxq;
		logic [W-1:0]  ryq;
		logic [W-1:0]  rxp;
		logic [W-1:0]  rqp;
		logic [W-1:0]  rdp;
		logic [W-1:0]  acc;
	} stage_t;

	// One restoring step: shift in a dividend bit, subtract m if it fits.
	function automatic logic [W-1:0] div_step(input logic [W-1:0] rem, input logic b,
			input logic [W-1:0] m);
		logic [W:0] sh;
		sh = {rem, b};
		if (m != '0 && sh >= {1'b0, m})
			sh = sh - {1'b0, m};
		return sh[W-1:0];
	endfunction

	// Add of two values already below m; zero modulus wraps.
	function automatic logic [W-1:0] add_m(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (m != '0 && s >= {1'b0, m})
			s = s - {1'b0, m};
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sub_m(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] m);
		logic [W-1:0] d;
		d = a - b;
		if (a < b)
			d = d + m;
		return d;
	endfunction

	logic [W-1:0] modulus_q;
	logic [W-1:0] target_q;
	stage_t       st [0:NST];
	stage_t       nx [0:NST];
	logic         en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(2);
			target_q  <= W'(2);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MODULUS: modulus_q <= cfg_wdata;
				REG_TARGET:  target_q  <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// Advance everything together unless the output item is held
	assign en        = !st[NST].vld || rsp.ready;
	assign req.ready = en;

	// Entry stage: snapshot operands and moduli, form |p - q|
	always_comb begin
		nx[0]      = '0;
		nx[0].vld  = req.valid;
		nx[0].op   = req.req_type;
		nx[0].x    = req.operand_a;
		nx[0].y    = req.operand_b;
		nx[0].q    = modulus_q;
		nx[0].p    = target_q;
		nx[0].qlp  = modulus_q < target_q;
		nx[0].diff = (modulus_q > target_q) ? (modulus_q - target_q)
		                                    : (target_q - modulus_q);
	end

	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_stage
			if (k <= W) begin : g_div
				// Remainder stages: one dividend bit, MSB first
				always_comb begin
					nx[k]     = st[k-1];
					nx[k].rxq = div_step(st[k-1].rxq, st[k-1].x[W-k], st[k-1].q);
					nx[k].ryq = div_step(st[k-1].ryq, st[k-1].y[W-k], st[k-1].q);
					nx[k].rxp = div_step(st[k-1].rxp, st[k-1].x[W-k], st[k-1].p);
					nx[k].rqp = div_step(st[k-1].rqp, st[k-1].q[W-k], st[k-1].p);
					nx[k].rdp = div_step(st[k-1].rdp, st[k-1].diff[W-k], st[k-1].p);
				end
			end else if (k == W + 1) begin : g_fix
				// Zero modulus means no reduction
				always_comb begin
					nx[k]     = st[k-1];
					nx[k].acc = '0;
					if (st[k-1].q == '0) begin
						nx[k].rxq = st[k-1].x;
						nx[k].ryq = st[k-1].y;
					end
					if (st[k-1].p == '0) begin
						nx[k].rxp = st[k-1].x;
						nx[k].rqp = st[k-1].q;
						nx[k].rdp = st[k-1].diff;
					end
				end
			end else if (k < NST) begin : g_mul
				// Double-and-add modular multiply, one multiplier bit per stage
				always_comb begin
					nx[k]     = st[k-1];
					nx[k].acc = add_m(add_m(st[k-1].acc, st[k-1].acc, st[k-1].q),
						st[k-1].ryq[2*W+1-k] ? st[k-1].rxq : '0, st[k-1].q);
				end
			end else begin : g_out
				// Output stage: pick the result for the request type
				always_comb begin
					logic hi;
					hi    = st[k-1].x > (st[k-1].q >> 1);
					nx[k] = st[k-1];
					case (st[k-1].op)
						OP_ADD:  nx[k].acc = add_m(st[k-1].rxq, st[k-1].ryq, st[k-1].q);
						OP_SUB:  nx[k].acc = sub_m(st[k-1].rxq, st[k-1].ryq, st[k-1].q);
						OP_MUL:  nx[k].acc = st[k-1].acc;
						OP_CRED: begin
							if (st[k-1].p == W'(2))
								nx[k].acc = W'(st[k-1].x[0] ^ hi);
							else if (hi)
								nx[k].acc = sub_m(st[k-1].rxp, st[k-1].rqp, st[k-1].p);
							else
								nx[k].acc = st[k-1].rxp;
						end
						OP_SWITCH: begin
							if (!hi)
								nx[k].acc = st[k-1].rxp;
							else if (st[k-1].qlp)
								nx[k].acc = add_m(st[k-1].rxp, st[k-1].rdp, st[k-1].p);
							else
								nx[k].acc = sub_m(st[k-1].rxp, st[k-1].rdp, st[k-1].p);
						end
						default: nx[k].acc = '0;
					endcase
				end
			end
		end

		for (k = 0; k <= NST; k++) begin : g_reg
			// Valid bit and payload: clear on reset, hold on stall
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					st[k] <= '0;
				else if (en)
					st[k] <= nx[k];
			end
		end
	endgenerate

	assign rsp.valid        = st[NST].vld;
	assign rsp.result_value = st[NST].acc;

	// Ring results must lie below q
	a_ring_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st[NST].vld && st[NST].q != '0 &&
		 (st[NST].op == OP_ADD || st[NST].op == OP_SUB || st[NST].op == OP_MUL))
		|-> (st[NST].acc < st[NST].q))
		else $error("ring result not reduced mod q");

	// Mapped results must lie below p
	a_map_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st[NST].vld && st[NST].p != '0 &&
		 (st[NST].op == OP_CRED || st[NST].op == OP_SWITCH))
		|-> (st[NST].acc < st[NST].p))
		else $error("mapped result not reduced mod p");

	// A held output item stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st[NST].vld && !rsp.ready) |=> (st[NST].vld && $stable(st[NST].acc)))
		else $error("held output changed");

endmodule
